// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: src/dht_pkg.sv
// package for the double hash table engine: widths, codes, control structs
// no dependencies
package dht_pkg;
	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BYTES = 8;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SIZE_W = 11;
	localparam int CNT_W = IDX_W + 1;
	localparam int HASH_W = 64;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_FOUND = 3'd2;
	localparam logic [2:0] ST_DELETED = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	// slot flags as {occupied, tombstone}
	localparam logic [1:0] FLAG_EMPTY = 2'b00;
	localparam logic [1:0] FLAG_LIVE = 2'b10;
	localparam logic [1:0] FLAG_TOMB = 2'b11;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MOD, S_READ, S_CHECK, S_WRITE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input beat, start reductions
		logic mod_step;  // one bit of both reductions
		logic read;      // issue slot read at current position
		logic advance;   // move to next probe position
		logic commit;    // write final result and any table update
		logic clear_out; // result taken
	} dht_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done; // flag clearing pass after reset finished
		logic mod_done;
		logic probe_end; // chain ends at this probe (empty, match or limit)
		logic out_valid;
	} dht_stat_t;
endpackage

// File: src/double_hash_table_engine.sv
// Double hashing key-value table. After reset a clearing pass walks the slot flags and holds
// in_stall high. Then one item is taken at a time: the hash is reduced modulo size and size-1
// (64 restoring steps of one bit, then a step that loads the start slot and probe step), each
// probe reads a slot and then checks it, and a commit writes the result register and any
// table update; the next beat is taken after the commit (probes from 1 up to the table size).
// A result held by out_stall delays the next commit.
// Top level; depends on dht_pkg, dht_ctrl, dht_datapath
module double_hash_table_engine import dht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] hash_key,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [31:0] value_handle,
	input  logic [15:0] value_size,
	input  logic [1:0]  value_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [9:0]  slot_index,
	output logic [31:0] found_handle,
	output logic [15:0] found_size,
	output logic [1:0]  found_type
);
	dht_cmd_t cmd;
	dht_stat_t stat;

	assign cfg_ready = 1'b1;

	dht_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_stall, .stat, .cmd
	);

	dht_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .cfg_valid(cfg_valid && cfg_ready), .cfg_data,
		.kind, .hash_key, .key_bytes, .key_length, .value_handle, .value_size,
		.value_type, .out_valid, .status, .slot_index, .found_handle, .found_size,
		.found_type
	);
endmodule

// File: src/dht_ctrl.sv
// controller state machine of the double hash table engine
// depends on dht_pkg
module dht_ctrl import dht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      out_stall,
	input  dht_stat_t stat,
	output dht_cmd_t  cmd
);
	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		cmd.clear_out = stat.out_valid && !out_stall;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.mod_done) state_d = S_READ;
				else cmd.mod_step = 1'b1;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.probe_end) state_d = S_WRITE;
				else begin
					cmd.advance = 1'b1;
					state_d = S_READ;
				end
			end
			S_WRITE: begin
				if (!stat.out_valid || !out_stall) begin
					cmd.commit = 1'b1;
					cmd.clear_out = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: src/dht_datapath.sv
// datapath: restoring modulo unit, probe walker, slot memory, result register
// depends on dht_pkg
module dht_datapath import dht_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dht_cmd_t          cmd,
	output dht_stat_t         stat,
	input  logic              cfg_valid,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic [1:0]        kind,
	input  logic [63:0]       hash_key,
	input  logic [63:0]       key_bytes,
	input  logic [3:0]        key_length,
	input  logic [31:0]       value_handle,
	input  logic [15:0]       value_size,
	input  logic [1:0]        value_type,
	output logic              out_valid,
	output logic [2:0]        status,
	output logic [9:0]        slot_index,
	output logic [31:0]       found_handle,
	output logic [15:0]       found_size,
	output logic [1:0]        found_type
);
	localparam int ENT_W = 64 + 4 + 32 + 16 + 2;

	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0] s_eff;
	logic [ENT_W-1:0] mem [TABLE_DEPTH];
	logic [1:0] flag_mem [TABLE_DEPTH];
	logic [IDX_W:0] clr_q;
	logic [ENT_W-1:0] rd_q;

	logic [1:0] kind_q;
	logic [63:0] key_q;
	logic [3:0] len_q;
	logic [31:0] vh_q;
	logic [15:0] vs_q;
	logic [1:0] vt_q;
	logic [HASH_W-1:0] sh_q;
	logic [CNT_W-1:0] r1_q, r2_q;
	logic [6:0] bit_q;
	logic [IDX_W-1:0] pos_q, step_q, free_q;
	logic have_free_q;
	logic [CNT_W-1:0] probes_q;
	logic rd_occ_q, rd_tomb_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= SIZE_W'(1021);
		else if (cfg_valid) size_q <= cfg_data;
	end

	// clearing pass over the slot flags after reset, one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (!clr_q[IDX_W]) clr_q <= clr_q + (IDX_W+1)'(1);
	end

	// effective size saturated to the legal range
	always_comb begin
		if (size_q < SIZE_W'(3)) s_eff = CNT_W'(3);
		else if (size_q > SIZE_W'(TABLE_DEPTH)) s_eff = CNT_W'(TABLE_DEPTH);
		else s_eff = CNT_W'(size_q);
	end

	// key masking and length saturation
	logic [3:0] len_sat;
	logic [63:0] key_m;
	always_comb begin
		len_sat = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
		for (int b = 0; b < 8; b++)
			key_m[b*8 +: 8] = (4'(b) < len_sat) ? key_bytes[b*8 +: 8] : 8'h00;
	end

	// one bit per cycle of hash mod s and hash mod (s-1)
	logic [CNT_W:0] t1, t2;
	logic [CNT_W-1:0] d2;
	assign d2 = s_eff - CNT_W'(1);
	assign t1 = {r1_q, sh_q[HASH_W-1]};
	assign t2 = {r2_q, sh_q[HASH_W-1]};

	// probe decode on registered read data
	logic live, match, last_probe;
	logic [IDX_W:0] pos_sum;
	assign live = rd_occ_q && !rd_tomb_q;
	assign match = live && rd_q[ENT_W-1 -: 64] == key_q && rd_q[ENT_W-65 -: 4] == len_q;
	assign last_probe = (probes_q + CNT_W'(1)) >= s_eff;
	assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};

	// status to controller
	always_comb begin
		stat.clear_done = clr_q[IDX_W];
		stat.mod_done = bit_q == 7'd64;
		stat.probe_end = !rd_occ_q || match || last_probe;
		stat.out_valid = out_valid;
	end

	// operation registers and probe walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind; key_q <= key_m; len_q <= len_sat;
			vh_q <= value_handle; vs_q <= value_size; vt_q <= value_type;
			sh_q <= hash_key; r1_q <= '0; r2_q <= '0; bit_q <= '0;
			have_free_q <= 1'b0; probes_q <= '0;
		end
		if (cmd.mod_step) begin
			r1_q <= (t1 >= {1'b0, s_eff}) ? CNT_W'(t1 - {1'b0, s_eff}) : CNT_W'(t1);
			r2_q <= (t2 >= {1'b0, d2}) ? CNT_W'(t2 - {1'b0, d2}) : CNT_W'(t2);
			sh_q <= {sh_q[HASH_W-2:0], 1'b0};
			bit_q <= bit_q + 7'd1;
		end
		if (stat.mod_done && !cmd.read && !cmd.advance && probes_q == '0
		    && !cmd.commit && bit_q == 7'd64) begin
			pos_q <= IDX_W'(r1_q);
			step_q <= IDX_W'(r2_q + CNT_W'(1));
			bit_q <= 7'd65;
		end
		if (cmd.read) begin
			rd_q <= mem[pos_q];
			{rd_occ_q, rd_tomb_q} <= flag_mem[pos_q];
		end
		// free slot capture on a tombstone passed over
		if (cmd.advance && !have_free_q && kind_q == KIND_INSERT && !live) begin
			have_free_q <= 1'b1;
			free_q <= pos_q;
		end
		if (cmd.advance) begin
			probes_q <= probes_q + CNT_W'(1);
			pos_q <= (pos_sum >= (IDX_W+1)'(s_eff)) ? IDX_W'(pos_sum - (IDX_W+1)'(s_eff))
			                                         : IDX_W'(pos_sum);
		end
	end

	// final decision
	logic ins_free;
	logic [IDX_W-1:0] ins_slot;
	always_comb begin
		ins_free = have_free_q || !live;
		ins_slot = have_free_q ? free_q : pos_q;
	end

	// table update
	always_ff @(posedge clk) begin
		if (cmd.commit && kind_q == KIND_INSERT) begin
			if (match) mem[pos_q][49:0] <= {vh_q, vs_q, vt_q};
			else if (ins_free) mem[ins_slot] <= {key_q, len_q, vh_q, vs_q, vt_q};
		end
	end

	// slot flags, cleared by the pass after reset
	always_ff @(posedge clk) begin
		if (!clr_q[IDX_W]) flag_mem[clr_q[IDX_W-1:0]] <= FLAG_EMPTY;
		else if (cmd.commit) begin
			if (kind_q == KIND_INSERT && !match && ins_free) flag_mem[ins_slot] <= FLAG_LIVE;
			else if (kind_q == KIND_DELETE && match) flag_mem[pos_q] <= FLAG_TOMB;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.commit) out_valid <= 1'b1;
		else if (cmd.clear_out) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status <= ST_NOT_FOUND; slot_index <= '0;
			found_handle <= '0; found_size <= '0; found_type <= '0;
			case (kind_q)
				KIND_INSERT: begin
					if (match) begin
						status <= ST_REPLACED; slot_index <= 10'(pos_q);
					end else if (ins_free) begin
						status <= ST_INSERTED; slot_index <= 10'(ins_slot);
					end else status <= ST_FULL;
				end
				KIND_SEARCH: if (match) begin
					status <= ST_FOUND; slot_index <= 10'(pos_q);
					found_handle <= rd_q[49:18]; found_size <= rd_q[17:2];
					found_type <= rd_q[1:0];
				end
				KIND_DELETE: if (match) begin
					status <= ST_DELETED; slot_index <= 10'(pos_q);
				end
				default: status <= ST_NOT_FOUND;
			endcase
		end
	end
endmodule

// File: src/dht_checker.sv
// port-level checker for the double hash table engine and its bind
// depends on assert_macros.svh and dht_pkg
`include "assert_macros.svh"
module dht_checker import dht_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] status,
	input logic [9:0] slot_index
);
	logic no_slot;
	assign no_slot = status == ST_NOT_FOUND || status == ST_FULL;

	// in_stall is raised right after a beat is taken
	`ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "busy after beat")
	`ASSERT_IMPL(a_status, clk, arst_n, out_valid, status <= ST_FULL, "bad status")
	`ASSERT_IMPL(a_slot0, clk, arst_n, out_valid && no_slot, slot_index == '0, "slot not zero")
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "result dropped")
endmodule

bind double_hash_table_engine dht_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .status, .slot_index
);
